// ----- sv/lpbc_pkg.sv -----
// Shared codes for the LRU pinned block cache tag controller.
// Request types, result status codes and register indexes. No dependencies.
package lpbc_pkg;

    localparam int unsigned CFG_ADDR_BITS = 3;

    localparam logic REQ_GET     = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [2:0] ST_HIT         = 3'd0;
    localparam logic [2:0] ST_MISS_FILLED = 3'd1;
    localparam logic [2:0] ST_RELEASED    = 3'd2;
    localparam logic [2:0] ST_BLOCK_ZERO  = 3'd3;
    localparam logic [2:0] ST_PAST_END    = 3'd4;
    localparam logic [2:0] ST_ALL_PINNED  = 3'd5;
    localparam logic [2:0] ST_CLOCK_WRAP  = 3'd6;

    localparam logic REG_TOTAL_BLOCKS = 1'b0;

endpackage

// ----- sv/lpbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpbc_ram #(
    parameter int WIDTH = 73,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/lru_pinned_block_cache.sv -----
// Tag controller of a fully associative write-back block cache, LRU with pins.
// A get scans the slot RAM, one slot entry read per cycle; a release reads and writes one entry,
// and a rejected get goes straight to the result. One item at a time.
// Reset: asynchronous, active low. After reset a clearing pass writes every slot entry,
// during which no item is taken; configuration writes are taken throughout.
// Depends on lpbc_pkg and lpbc_ram.
module lru_pinned_block_cache #(
    parameter int SLOTS    = 64,
    parameter int PIN_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpbc_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [31:0]                       block_number,
    input  logic [5:0]                        release_slot,
    input  logic                              mark_dirty,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        status,
    output logic [5:0]                        slot,
    output logic                              writeback_needed,
    output logic [31:0]                       writeback_block
);

    import lpbc_pkg::*;

    localparam int AW     = $clog2(SLOTS);
    localparam int EW     = 32 + 32 + PIN_BITS + 1;
    localparam int TAG_LO = 32 + PIN_BITS + 1;
    localparam int STP_LO = PIN_BITS + 1;
    localparam int PIN_LO = 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_REL_RD, S_REL_WR, S_SCAN, S_SCAN_LAST, S_UPDATE, S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [31:0]         total_blocks_reg;
    logic [31:0]         use_clock_reg, use_clock_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [AW-1:0]       chk_idx_reg, chk_idx_next;

    logic                req_type_reg, req_type_next;
    logic [31:0]         req_blk_reg, req_blk_next;
    logic [5:0]          req_rslot_reg, req_rslot_next;
    logic                req_dirty_reg, req_dirty_next;

    logic                hit_found_reg, hit_found_next;
    logic [AW-1:0]       hit_idx_reg, hit_idx_next;
    logic [PIN_BITS-1:0] hit_pins_reg, hit_pins_next;
    logic                hit_dirty_reg, hit_dirty_next;

    logic                have_vic_reg, have_vic_next;
    logic [AW-1:0]       vic_idx_reg, vic_idx_next;
    logic [31:0]         vic_stamp_reg, vic_stamp_next;
    logic [31:0]         vic_tag_reg, vic_tag_next;
    logic [PIN_BITS-1:0] vic_pins_reg, vic_pins_next;
    logic                vic_dirty_reg, vic_dirty_next;

    logic [2:0]          res_status_reg, res_status_next;
    logic [5:0]          res_slot_reg, res_slot_next;
    logic                res_wb_reg, res_wb_next;
    logic [31:0]         res_wblk_reg, res_wblk_next;

    logic                out_valid_reg, out_valid_next;
    logic [2:0]          out_status_reg, out_status_next;
    logic [5:0]          out_slot_reg, out_slot_next;
    logic                out_wb_reg, out_wb_next;
    logic [31:0]         out_wblk_reg, out_wblk_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_rdata;

    logic [31:0]         rd_tag;
    logic [31:0]         rd_stamp;
    logic [PIN_BITS-1:0] rd_pins;
    logic                rd_dirty;
    logic                cnt_last;
    logic [AW-1:0]       rel_addr;
    logic                rel_ok;
    logic                cfg_wr;

    logic [AW-1:0]       upd_idx;
    logic [PIN_BITS-1:0] upd_pins;
    logic [PIN_BITS-1:0] upd_pins_inc;
    logic                upd_dirty;
    logic [31:0]         clock_inc;

    lpbc_ram #(
        .WIDTH(EW),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_tag   = ram_rdata[TAG_LO +: 32];
    assign rd_stamp = ram_rdata[STP_LO +: 32];
    assign rd_pins  = ram_rdata[PIN_LO +: PIN_BITS];
    assign rd_dirty = ram_rdata[0];

    assign cnt_last = (cnt_reg == AW'(SLOTS - 1));
    assign rel_addr = AW'(req_rslot_reg);
    assign rel_ok   = (32'(req_rslot_reg) < 32'(SLOTS));
    assign clock_inc = use_clock_reg + 32'd1;

    assign upd_idx      = hit_found_reg ? hit_idx_reg : vic_idx_reg;
    assign upd_pins     = hit_found_reg ? hit_pins_reg : vic_pins_reg;
    assign upd_dirty    = hit_found_reg ? hit_dirty_reg : 1'b0;
    assign upd_pins_inc = (upd_pins == {PIN_BITS{1'b1}}) ? upd_pins
                                                         : upd_pins + PIN_BITS'(1);

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_TOTAL_BLOCKS);
    assign prdata   = (paddr[2] == REG_TOTAL_BLOCKS) ? total_blocks_reg : 32'd0;

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign slot             = out_slot_reg;
    assign writeback_needed = out_wb_reg;
    assign writeback_block  = out_wblk_reg;

    always_comb
    begin
        state_next      = state_reg;
        use_clock_next  = use_clock_reg;
        cnt_next        = cnt_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        req_type_next   = req_type_reg;
        req_blk_next    = req_blk_reg;
        req_rslot_next  = req_rslot_reg;
        req_dirty_next  = req_dirty_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_pins_next   = hit_pins_reg;
        hit_dirty_next  = hit_dirty_reg;
        have_vic_next   = have_vic_reg;
        vic_idx_next    = vic_idx_reg;
        vic_stamp_next  = vic_stamp_reg;
        vic_tag_next    = vic_tag_reg;
        vic_pins_next   = vic_pins_reg;
        vic_dirty_next  = vic_dirty_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_wb_next     = res_wb_reg;
        res_wblk_next   = res_wblk_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_wb_next     = out_wb_reg;
        out_wblk_next   = out_wblk_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg;
        ram_wdata       = '0;
        ram_raddr       = cnt_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = '0;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_type_next  = req_type;
                    req_blk_next   = block_number;
                    req_rslot_next = release_slot;
                    req_dirty_next = mark_dirty;
                    res_slot_next  = 6'd0;
                    res_wb_next    = 1'b0;
                    res_wblk_next  = 32'd0;
                    if (req_type == REQ_RELEASE)
                    begin
                        state_next = S_REL_RD;
                    end
                    else if (block_number == 32'd0)
                    begin
                        res_status_next = ST_BLOCK_ZERO;
                        state_next      = S_EMIT;
                    end
                    else if (block_number >= total_blocks_reg)
                    begin
                        res_status_next = ST_PAST_END;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        cnt_next       = '0;
                        hit_found_next = 1'b0;
                        have_vic_next  = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_REL_RD:
            begin
                ram_raddr  = rel_addr;
                state_next = S_REL_WR;
            end
            S_REL_WR:
            begin
                if (rel_ok)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rel_addr;
                    ram_wdata = ram_rdata;
                    if (rd_pins != '0)
                    begin
                        ram_wdata[PIN_LO +: PIN_BITS] = rd_pins - PIN_BITS'(1);
                    end
                    if (req_dirty_reg)
                    begin
                        ram_wdata[0] = 1'b1;
                    end
                end
                res_status_next = ST_RELEASED;
                res_slot_next   = req_rslot_reg;
                state_next      = S_EMIT;
            end
            S_SCAN:
            begin
                ram_raddr    = cnt_reg;
                chk_vld_next = 1'b1;
                chk_idx_next = cnt_reg;
                cnt_next     = cnt_reg + AW'(1);
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = S_SCAN_LAST;
                end
            end
            S_SCAN_LAST:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (hit_found_reg || have_vic_reg)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = upd_idx;
                    ram_wdata      = {req_blk_reg, clock_inc, upd_pins_inc, upd_dirty};
                    use_clock_next = clock_inc;
                    res_slot_next  = 6'(upd_idx);
                    if (hit_found_reg)
                    begin
                        res_status_next = ST_HIT;
                    end
                    else
                    begin
                        res_status_next = ST_MISS_FILLED;
                        if (vic_tag_reg != 32'd0 && vic_dirty_reg)
                        begin
                            res_wb_next   = 1'b1;
                            res_wblk_next = vic_tag_reg;
                        end
                    end
                    if (clock_inc == 32'd0)
                    begin
                        res_status_next = ST_CLOCK_WRAP;
                    end
                end
                else
                begin
                    res_status_next = ST_ALL_PINNED;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_wb_next     = res_wb_reg;
                    out_wblk_next   = res_wblk_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // compare the entry read in the previous cycle
        if (chk_vld_reg)
        begin
            if (!hit_found_reg && rd_tag == req_blk_reg)
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = chk_idx_reg;
                hit_pins_next  = rd_pins;
                hit_dirty_next = rd_dirty;
            end
            if (rd_pins == '0 && (!have_vic_reg || rd_stamp < vic_stamp_reg))
            begin
                have_vic_next  = 1'b1;
                vic_idx_next   = chk_idx_reg;
                vic_stamp_next = rd_stamp;
                vic_tag_next   = rd_tag;
                vic_pins_next  = rd_pins;
                vic_dirty_next = rd_dirty;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            total_blocks_reg <= 32'd0;
            use_clock_reg    <= 32'd1;
            cnt_reg          <= '0;
            chk_vld_reg      <= 1'b0;
            chk_idx_reg      <= '0;
            req_type_reg     <= REQ_GET;
            req_blk_reg      <= 32'd0;
            req_rslot_reg    <= 6'd0;
            req_dirty_reg    <= 1'b0;
            hit_found_reg    <= 1'b0;
            hit_idx_reg      <= '0;
            hit_pins_reg     <= '0;
            hit_dirty_reg    <= 1'b0;
            have_vic_reg     <= 1'b0;
            vic_idx_reg      <= '0;
            vic_stamp_reg    <= 32'd0;
            vic_tag_reg      <= 32'd0;
            vic_pins_reg     <= '0;
            vic_dirty_reg    <= 1'b0;
            res_status_reg   <= ST_HIT;
            res_slot_reg     <= 6'd0;
            res_wb_reg       <= 1'b0;
            res_wblk_reg     <= 32'd0;
            out_valid_reg    <= 1'b0;
            out_status_reg   <= ST_HIT;
            out_slot_reg     <= 6'd0;
            out_wb_reg       <= 1'b0;
            out_wblk_reg     <= 32'd0;
        end
        else
        begin
            state_reg      <= state_next;
            use_clock_reg  <= use_clock_next;
            cnt_reg        <= cnt_next;
            chk_vld_reg    <= chk_vld_next;
            chk_idx_reg    <= chk_idx_next;
            req_type_reg   <= req_type_next;
            req_blk_reg    <= req_blk_next;
            req_rslot_reg  <= req_rslot_next;
            req_dirty_reg  <= req_dirty_next;
            hit_found_reg  <= hit_found_next;
            hit_idx_reg    <= hit_idx_next;
            hit_pins_reg   <= hit_pins_next;
            hit_dirty_reg  <= hit_dirty_next;
            have_vic_reg   <= have_vic_next;
            vic_idx_reg    <= vic_idx_next;
            vic_stamp_reg  <= vic_stamp_next;
            vic_tag_reg    <= vic_tag_next;
            vic_pins_reg   <= vic_pins_next;
            vic_dirty_reg  <= vic_dirty_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_wb_reg     <= res_wb_next;
            res_wblk_reg   <= res_wblk_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_wb_reg     <= out_wb_next;
            out_wblk_reg   <= out_wblk_next;
            if (cfg_wr)
            begin
                total_blocks_reg <= pwdata;
            end
        end
    end

endmodule
